[hw/rtl/tsd_pkg.sv]
package tsd_pkg;

  localparam int unsigned SideDepth = 256;
  localparam int unsigned DataWidth = 32;

  localparam int unsigned CountW = $clog2(SideDepth + 1);
  localparam int unsigned AddrW  = (SideDepth > 1) ? $clog2(SideDepth) : 1;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned ResW    = 32;
  localparam int unsigned ErrW    = 2;
  localparam int unsigned SizeW   = 10;

  // value | index, padded to whole bytes
  localparam int unsigned InTdataW  = ((ValueW + IndexW + 7) / 8) * 8;
  // data | size | is_empty, padded to whole bytes
  localparam int unsigned OutTdataW = ((ResW + SizeW + 1 + 7) / 8) * 8;

  typedef enum logic [FuncW-1:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_READ_IDX   = 3'd2,
    FN_READ_FRONT = 3'd3,
    FN_READ_BACK  = 3'd4
  } tsd_func_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE  = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_FULL  = 2'd3
  } tsd_err_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } tsd_state_e;

  // Lookup token travelling down the cell row
  typedef struct packed {
    logic                 valid;
    logic                 side;   // 0 front store, 1 back store
    logic [AddrW-1:0]     addr;
    logic [DataWidth-1:0] data;
  } tsd_tok_t;

  // Push broadcast to every cell
  typedef struct packed {
    logic                 front_en;
    logic                 back_en;
    logic [AddrW-1:0]     addr;
    logic [DataWidth-1:0] data;
  } tsd_wr_t;

  // Sign-extend a stored element to the result width
  function automatic logic [ResW-1:0] out_data(input logic [DataWidth-1:0] x);
    logic signed [DataWidth-1:0] s;
    s = x;
    return ResW'(s);
  endfunction

endpackage

[hw/rtl/two_stack_deque_unit.sv]
// Double-ended queue that only grows, kept as two stacks in a row of cells.
// Input channel s_axis: tuser carries the operation (push back, push front,
// read at index, read front, read back); tdata carries the pushed value and
// the logical index. Output channel m_axis: one item per input item; tuser
// carries the error code, tdata the element read, the size after the
// operation and the empty flag.
// Each cell holds one entry of the front stack and one of the back stack.
// A push writes its cell directly, so its result is shown in the cycle after
// acceptance. A read launches a token that hops one cell per cycle and picks
// up the entry on its way; its result is registered once the token leaves
// the last cell. One item is in flight at a time: a read holds off the next
// item until its token has left the cell row.
// The output register holds a finished result while the receiver stalls;
// the next item is accepted in the cycle that result is taken.
// Reset clears both counts and empties the token row; store contents are
// left as they are and are only read below the counts.
module two_stack_deque_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [31:0] value, [41:32] index, [47:42] zero
  input  logic [tsd_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // [2:0] func
  input  logic [tsd_pkg::FuncW-1:0]     s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] data, [41:32] size, [42] is_empty, [47:43] zero
  output logic [tsd_pkg::OutTdataW-1:0] m_axis_tdata_o,
  // [1:0] error
  output logic [tsd_pkg::ErrW-1:0]      m_axis_tuser_o
);
  import tsd_pkg::*;

  tsd_wr_t              wr;
  tsd_tok_t             tok [SideDepth+1];
  logic [SideDepth-1:0] tok_vld;

  // Sequencer: counts, decode, result register
  tsd_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .wr_o     (wr),
    .launch_o (tok[0]),
    .exit_i   (tok[SideDepth])
  );

  // Cell row: each cell passes the lookup token on to its neighbour
  for (genvar k = 0; k < SideDepth; k++) begin : g_cell
    tsd_cell u_cell (
      .clk_i,
      .rst_ni,
      .idx_i (AddrW'(k)),
      .wr_i  (wr),
      .tok_i (tok[k]),
      .tok_o (tok[k+1])
    );
    assign tok_vld[k] = tok[k+1].valid;
  end

  // At most one lookup in the row
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(tok_vld))
    else $error("more than one token in the cell row");

  // A token leaves only into an empty output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[SideDepth].valid |-> !m_axis_tvalid_o)
    else $error("token left while a result was pending");

  // Failed operations return zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != ERR_NONE)) |-> (m_axis_tdata_o[ResW-1:0] == '0))
    else $error("error result with non-zero data");

  // Empty flag agrees with size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[ResW+SizeW]) |->
    (m_axis_tdata_o[ResW+SizeW-1:ResW] == '0))
    else $error("empty flag set with non-zero size");

endmodule

[hw/rtl/tsd_cell.sv]
module tsd_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [tsd_pkg::AddrW-1:0] idx_i,
  input  tsd_pkg::tsd_wr_t         wr_i,
  input  tsd_pkg::tsd_tok_t        tok_i,
  output tsd_pkg::tsd_tok_t        tok_o
);
  import tsd_pkg::*;

  logic [DataWidth-1:0] front_q;
  logic [DataWidth-1:0] back_q;
  logic                 tok_vld_q;
  logic                 tok_side_q;
  logic [AddrW-1:0]     tok_addr_q;
  logic [DataWidth-1:0] tok_data_q;
  logic [DataWidth-1:0] tok_data_d;
  logic                 hit;

  // entries of this position in both stores
  always_ff @(posedge clk_i) begin
    if (wr_i.front_en && (wr_i.addr == idx_i)) begin
      front_q <= wr_i.data;
    end
    if (wr_i.back_en && (wr_i.addr == idx_i)) begin
      back_q <= wr_i.data;
    end
  end

  assign hit = tok_i.valid && (tok_i.addr == idx_i);

  always_comb begin
    tok_data_d = tok_i.data;
    if (hit) begin
      tok_data_d = tok_i.side ? back_q : front_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_i.valid;
    end
  end

  // advance the token payload one position
  always_ff @(posedge clk_i) begin
    tok_side_q <= tok_i.side;
    tok_addr_q <= tok_i.addr;
    tok_data_q <= tok_data_d;
  end

  assign tok_o = '{valid: tok_vld_q, side: tok_side_q, addr: tok_addr_q, data: tok_data_q};

endmodule

[hw/rtl/tsd_ctrl.sv]
module tsd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [tsd_pkg::InTdataW-1:0]  s_axis_tdata_i,
  input  logic [tsd_pkg::FuncW-1:0]     s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [tsd_pkg::OutTdataW-1:0] m_axis_tdata_o,
  output logic [tsd_pkg::ErrW-1:0]      m_axis_tuser_o,
  output tsd_pkg::tsd_wr_t              wr_o,
  output tsd_pkg::tsd_tok_t             launch_o,
  input  tsd_pkg::tsd_tok_t             exit_i
);
  import tsd_pkg::*;

  tsd_state_e state_q, state_d;

  logic [CountW-1:0] fc_q, fc_d;
  logic [CountW-1:0] bc_q, bc_d;
  logic              out_vld_q, out_vld_d;
  logic [ResW-1:0]   res_data_q, res_data_d;
  logic [ErrW-1:0]   res_err_q, res_err_d;
  logic [SizeW-1:0]  res_size_q, res_size_d;
  logic              res_empty_q, res_empty_d;

  logic [ValueW-1:0] value;
  logic [IndexW-1:0] idx;
  logic              accept;
  logic              need_read;
  logic              rd_side;
  logic [AddrW-1:0]  rd_addr;
  tsd_err_e          err;
  logic [31:0]       fc_w, bc_w, idx_w, total_w, total_new;

  assign value = s_axis_tdata_i[ValueW-1:0];
  assign idx   = s_axis_tdata_i[ValueW+IndexW-1:ValueW];
  assign fc_w  = 32'(fc_q);
  assign bc_w  = 32'(bc_q);
  assign idx_w = 32'(idx);
  assign total_w = fc_w + bc_w;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && need_read) state_d = ST_WALK;
      ST_WALK: if (exit_i.valid) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    case (state_q)
      ST_IDLE: s_axis_tready_o = !out_vld_q || m_axis_tready_i;
      default: s_axis_tready_o = 1'b0;
    endcase
  end

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // decode the operation against the current counts
  always_comb begin
    fc_d      = fc_q;
    bc_d      = bc_q;
    err       = ERR_NONE;
    need_read = 1'b0;
    rd_side   = 1'b0;
    rd_addr   = '0;
    wr_o      = '{front_en: 1'b0, back_en: 1'b0, addr: '0, data: DataWidth'(value)};
    case (tsd_func_e'(s_axis_tuser_i))
      FN_PUSH_BACK: begin
        if (bc_q >= CountW'(SideDepth)) begin
          err = ERR_FULL;
        end else begin
          wr_o.back_en = accept;
          wr_o.addr    = AddrW'(bc_q);
          bc_d         = bc_q + CountW'(1);
        end
      end
      FN_PUSH_FRONT: begin
        if (fc_q >= CountW'(SideDepth)) begin
          err = ERR_FULL;
        end else begin
          wr_o.front_en = accept;
          wr_o.addr     = AddrW'(fc_q);
          fc_d          = fc_q + CountW'(1);
        end
      end
      FN_READ_IDX: begin
        if (idx_w >= total_w) begin
          err = ERR_RANGE;
        end else if (idx_w < fc_w) begin
          need_read = 1'b1;
          rd_addr   = AddrW'(fc_w - idx_w - 32'd1);
        end else begin
          need_read = 1'b1;
          rd_side   = 1'b1;
          rd_addr   = AddrW'(idx_w - fc_w);
        end
      end
      FN_READ_FRONT: begin
        if (fc_q != '0) begin
          need_read = 1'b1;
          rd_addr   = AddrW'(fc_w - 32'd1);
        end else if (bc_q != '0) begin
          need_read = 1'b1;
          rd_side   = 1'b1;
        end else begin
          err = ERR_EMPTY;
        end
      end
      FN_READ_BACK: begin
        if (bc_q != '0) begin
          need_read = 1'b1;
          rd_side   = 1'b1;
          rd_addr   = AddrW'(bc_w - 32'd1);
        end else if (fc_q != '0) begin
          need_read = 1'b1;
        end else begin
          err = ERR_EMPTY;
        end
      end
      default: ;
    endcase
  end

  assign total_new = 32'(fc_d) + 32'(bc_d);
  assign launch_o  = '{valid: accept && need_read, side: rd_side, addr: rd_addr, data: '0};

  // result register
  always_comb begin
    out_vld_d   = out_vld_q;
    res_data_d  = res_data_q;
    res_err_d   = res_err_q;
    res_size_d  = res_size_q;
    res_empty_d = res_empty_q;
    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    if (accept) begin
      res_err_d   = err;
      res_size_d  = SizeW'(total_new);
      res_empty_d = (total_new == 32'd0);
      res_data_d  = '0;
      out_vld_d   = !need_read;
    end
    if (exit_i.valid) begin
      res_data_d = out_data(exit_i.data);
      out_vld_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fc_q      <= '0;
      bc_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (accept) begin
        fc_q <= fc_d;
        bc_q <= bc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_data_q  <= res_data_d;
    res_err_q   <= res_err_d;
    res_size_q  <= res_size_d;
    res_empty_q <= res_empty_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = res_err_q;
  assign m_axis_tdata_o  = OutTdataW'({res_empty_q, res_size_q, res_data_q});

endmodule
